// File: hw/rtl/supply_voltage_from_reference_avg_assert.svh
// assertion macros used by the top rtl file
`ifndef SUPPLY_VOLTAGE_FROM_REFERENCE_AVG_ASSERT_SVH
`define SUPPLY_VOLTAGE_FROM_REFERENCE_AVG_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define SVFRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("svfra assertion failed");
// checked on every edge, reset included
`define SVFRA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("svfra assertion failed");
`else
`define SVFRA_ASSERT(lbl, prop)
`define SVFRA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: hw/rtl/svfra_pkg.sv
package svfra_pkg;

  localparam int CAL_W       = 12;
  localparam int RAW_W       = 12;
  localparam int MV_W        = 16;
  localparam int NUM_W       = 24;  // 3000 * 4095 fits in 24 bits
  localparam int COUNT_OUT_W = 5;
  localparam int MV_SCALE    = 3000;

  localparam logic [CAL_W-1:0] CAL_RESET = 12'd1671;
  localparam logic [MV_W-1:0]  MV_SAT    = 16'hFFFF;

  localparam logic OP_CONV  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic             op;
    logic [RAW_W-1:0] raw_sample;
  } in_word_t;

  typedef struct packed {
    logic [MV_W-1:0]        sample_mv;
    logic [MV_W-1:0]        average_mv;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   buffer_full;
    logic                   sample_dropped;
    logic                   saturated;
  } out_word_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic last;  // final quotient bit is taken at this edge
  } div_sts_t;

endpackage

// File: hw/rtl/supply_voltage_from_reference_avg.sv
// channel  | direction | handshake          | word
// ---------+-----------+--------------------+---------------------------------
// in_      | in        | in_valid/in_stall  | in_word_t: op, raw_sample
// out_     | out       | out_valid/out_stall| out_word_t: mv, average, count,
//          |           |                    |   full, dropped, saturated flags
// cfg_     | in        | cfg_wr_en          | cfg_wr_data: reference calibration
//
// conversion: accepted, 24 quotient bits on the restoring divider, then the
// finish state; the next word is accepted once the block is back in idle
// clear, dropped and zero-reading words skip the divider and go to finish
// reset (rst_n low, synchronous) empties average and count, calibration
// returns to 1671, and no result is pending
// a stalled result holds in the output register; the next word is still
// accepted, and its finish waits until the output register frees

`include "supply_voltage_from_reference_avg_assert.svh"

module supply_voltage_from_reference_avg #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  svfra_pkg::in_word_t           in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output svfra_pkg::out_word_t          out_word,
  input  logic                          cfg_wr_en,
  input  logic [svfra_pkg::CAL_W-1:0]   cfg_wr_data
);
  import svfra_pkg::*;

  // count must hold the depth itself
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CAL_W-1:0] cal_r;
  logic [MV_W-1:0]  avg_r, avg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             op_r;
  logic [RAW_W-1:0] raw_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             accept;
  logic             full;
  logic             out_free;
  logic             out_load;
  logic [NUM_W-1:0] numer;
  logic [NUM_W-1:0] quotient;
  logic             sat;
  logic [MV_W-1:0]  mv;
  logic [MV_W:0]    avg_sum;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r >= CNT_W'(BUFFER_DEPTH));
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_FIN) && out_free;

  // scale once per conversion, registered inside the divider at start
  assign numer = NUM_W'(cal_r) * NUM_W'(MV_SCALE);

  // a zero reading skips the divider and saturates directly
  assign div_ctl.start = accept && (in_word.op == OP_CONV) && !full
                         && (in_word.raw_sample != '0);

  svfra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .numer    (numer),
    .denom    (in_word.raw_sample),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // saturate on zero reading or quotient past 16 bits
  assign sat     = (raw_r == '0) || (quotient[NUM_W-1:MV_W] != '0);
  assign mv      = sat ? MV_SAT : quotient[MV_W-1:0];
  assign avg_sum = {1'b0, avg_r} + {1'b0, mv};

  always_comb begin
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    cnt_wide      = '0;

    case (state_r)
      ST_IDLE: begin
        if (div_ctl.start) begin
          state_nxt = ST_DIV;
        end else if (accept) begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_sts.last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_word_nxt = '0;
          if (op_r == OP_CLEAR) begin
            avg_nxt = '0;
            cnt_nxt = '0;
          end else if (full) begin
            out_word_nxt.sample_dropped = 1'b1;
          end else begin
            // halving average, in arrival order
            avg_nxt                = avg_sum[MV_W:1];
            cnt_nxt                = cnt_r + CNT_W'(1);
            out_word_nxt.sample_mv = mv;
            out_word_nxt.saturated = sat;
          end
          cnt_wide                    = {{COUNT_OUT_W{1'b0}}, cnt_nxt};
          out_word_nxt.average_mv     = avg_nxt;
          out_word_nxt.sample_count   = cnt_wide[COUNT_OUT_W-1:0];
          out_word_nxt.buffer_full    = (cnt_nxt >= CNT_W'(BUFFER_DEPTH));
          out_valid_nxt               = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cal_r       <= CAL_RESET;
      avg_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avg_r       <= avg_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cal_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (accept) begin
      op_r  <= in_word.op;
      raw_r <= in_word.raw_sample;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `SVFRA_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(BUFFER_DEPTH))
  `SVFRA_ASSERT(a_div_in_div_state, div_sts.busy |-> state_r == ST_DIV)
  `SVFRA_ASSERT(a_accept_leaves_idle, accept |=> state_r != ST_IDLE)
  `SVFRA_ASSERT(a_drop_means_full,
    out_valid_r && out_word_r.sample_dropped |-> out_word_r.buffer_full)
  `SVFRA_ASSERT(a_sat_value, out_valid_r && out_word_r.saturated |->
    out_word_r.sample_mv == MV_SAT)
  `SVFRA_ASSERT_ALWAYS(a_reset_no_result, !rst_n |=> !out_valid_r)

endmodule

// File: hw/rtl/svfra_div.sv
module svfra_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  svfra_pkg::div_ctl_t           ctl,
  input  logic [svfra_pkg::NUM_W-1:0]   numer,
  input  logic [svfra_pkg::RAW_W-1:0]   denom,
  output svfra_pkg::div_sts_t           sts,
  output logic [svfra_pkg::NUM_W-1:0]   quotient
);
  import svfra_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RAW_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [RAW_W-1:0]  den_r, den_nxt;

  logic [RAW_W:0]    rem_sh;
  logic [RAW_W+1:0]  diff;
  logic              fits;
  logic              last;

  // one restoring step per cycle, msb first
  always_comb begin
    rem_sh = {rem_r, quo_r[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    fits   = !diff[RAW_W+1];
    last   = busy_r && (step_r == STEP_W'(NUM_W-1));

    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = numer;
      den_nxt  = denom;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[RAW_W-1:0] : rem_sh[RAW_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.last = last;
  assign quotient = quo_r;

endmodule

// File: tb/sv/tb.sv
module tb;
  import svfra_pkg::*;

  // block size and run bounds
  localparam int          DEPTH       = 16;
  localparam int unsigned SCALE_MV    = 3 * 1000;
  localparam int          PHASE_WORDS = 225;
  localparam int          LONG_HOLD   = 500;
  localparam int          TAIL_CYCLES = 40;
  localparam int          CYCLE_LIMIT = 2000000;
  localparam int          NUM_PHASES  = 6;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  in_word_t             in_word     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  out_word_t            out_word;
  logic                 cfg_wr_en   = 1'b0;
  logic [CAL_W-1:0]     cfg_wr_data = '0;

  // words waiting for the driver, and readings the block still owes us
  in_word_t  conversion_queue[$];
  out_word_t expected_readings[$];

  // shadow of the block state, updated as each word is accepted
  logic [CAL_W-1:0] model_cal   = CAL_RESET;
  logic [MV_W-1:0]  model_avg   = '0;
  int unsigned      model_count = 0;

  // run control shared between the sequencer and the two handshake sides
  bit          calm           = 1'b0;
  bit          long_hold_req  = 1'b0;
  bit          long_hold_done = 1'b0;
  int          gap_left       = 0;
  int          stall_left     = 0;
  int          run_left       = 0;
  int unsigned cycle_count    = 0;
  int unsigned errors         = 0;
  int unsigned readings_checked = 0;
  int unsigned n_conversions  = 0;
  int unsigned n_saturated    = 0;
  int unsigned n_dropped      = 0;
  int unsigned n_clears       = 0;

  supply_voltage_from_reference_avg #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // idle lengths: mostly none or short, now and then a long one
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // raw readings: zero, near the saturation edge for this calibration,
  // top of range, or anywhere
  function automatic logic [RAW_W-1:0] pick_raw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 3) return RAW_W'($urandom_range(0, model_cal / 21 + 4));
    if (r == 3) return RAW_W'($urandom_range(4090, 4095));
    return RAW_W'($urandom_range(0, 4095));
  endfunction

  // predicted reading for one accepted word; advances the shadow state
  function automatic out_word_t predict_reading(input in_word_t w);
    out_word_t   r;
    int unsigned quotient;
    int unsigned sum;
    r = '0;
    if (w.op == OP_CLEAR) begin
      model_avg   = '0;
      model_count = 0;
      n_clears++;
    end else if (model_count >= DEPTH) begin
      // full: state held, word flagged and otherwise ignored
      r.sample_dropped = 1'b1;
      n_dropped++;
    end else begin
      if (w.raw_sample == '0) begin
        r.sample_mv = MV_SAT;
        r.saturated = 1'b1;
      end else begin
        quotient = (SCALE_MV * model_cal) / w.raw_sample;
        if (quotient > 32'hFFFF) begin
          r.sample_mv = MV_SAT;
          r.saturated = 1'b1;
        end else begin
          r.sample_mv = MV_W'(quotient);
        end
      end
      // halving average, in arrival order
      sum = model_avg + r.sample_mv;
      model_avg = MV_W'(sum >> 1);
      model_count++;
      n_conversions++;
      if (r.saturated) n_saturated++;
    end
    r.average_mv   = model_avg;
    r.sample_count = COUNT_OUT_W'(model_count);
    r.buffer_full  = (model_count >= DEPTH);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  function automatic in_word_t make_word(input logic op, input logic [RAW_W-1:0] raw);
    in_word_t w;
    w.op         = op;
    w.raw_sample = raw;
    return w;
  endfunction

  // driver: predicts on acceptance, then offers the next queued word after its gap
  always @(posedge clk) begin : drive_proc
    bit offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading(in_word));
        offering = 1'b0;
      end
      // a word still waiting on stall keeps valid and payload untouched
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (conversion_queue.size() > 0) begin
          in_word  <= conversion_queue.pop_front();
          in_valid <= 1'b1;
          gap_left = calm ? 0 : rand_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: alternating stall and free stretches, plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      run_left   = 0;
    end else if (long_hold_req && !long_hold_done) begin
      // long hold so the block backs up and stalls its input side
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD;
      run_left   = 0;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      stall_left = calm ? 0 : rand_len();
      run_left   = calm ? 50 : rand_len();
    end
  end

  // monitor: each accepted reading against the oldest prediction
  always @(posedge clk) begin : monitor_proc
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $display("%0t unexpected reading: expected none actual %h", $time, out_word);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        check_field("sample_mv", want.sample_mv, out_word.sample_mv);
        check_field("average_mv", want.average_mv, out_word.average_mv);
        check_field("sample_count", want.sample_count, out_word.sample_count);
        check_field("buffer_full", want.buffer_full, out_word.buffer_full);
        check_field("sample_dropped", want.sample_dropped, out_word.sample_dropped);
        check_field("saturated", want.saturated, out_word.saturated);
        readings_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("supply_voltage_from_reference_avg verification failed");
      $finish;
    end
  end

  // everything sent and every reading back: safe for a calibration write
  // sampled at the falling edge, once the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (conversion_queue.size() != 0 || in_valid || expected_readings.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_cal(input logic [CAL_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_cal = value;
    @(posedge clk);
  endtask

  // random traffic: mostly clear-then-fill runs, some without a clear,
  // long enough at times to overflow into drops, plus loose noise words
  task automatic queue_random(input int count);
    int made;
    int k;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 7) == 0) begin
        conversion_queue.push_back(make_word(1'($urandom_range(0, 1)),
                                             RAW_W'($urandom_range(0, 4095))));
        made++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          conversion_queue.push_back(make_word(OP_CLEAR, RAW_W'($urandom_range(0, 4095))));
          made++;
        end
        k = $urandom_range(1, 22);
        repeat (k) begin
          conversion_queue.push_back(make_word(OP_CONV, pick_raw()));
          made++;
        end
      end
    end
  endtask

  initial begin : sequencer
    logic [CAL_W-1:0] cal_plan [NUM_PHASES];
    cal_plan[0] = 12'hFFF;
    cal_plan[1] = 12'h000;
    cal_plan[2] = CAL_W'($urandom_range(0, 4095));
    cal_plan[3] = 12'h001;
    cal_plan[4] = CAL_W'($urandom_range(0, 4095));
    cal_plan[5] = CAL_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset calibration
    conversion_queue.push_back(make_word(OP_CONV, 12'd0));     // zero reading
    conversion_queue.push_back(make_word(OP_CONV, 12'd1));     // quotient far too large
    conversion_queue.push_back(make_word(OP_CONV, 12'd76));    // just over 16 bits
    conversion_queue.push_back(make_word(OP_CONV, 12'd77));    // just under
    conversion_queue.push_back(make_word(OP_CONV, 12'hFFF));
    conversion_queue.push_back(make_word(OP_CONV, 12'hAAA));
    conversion_queue.push_back(make_word(OP_CONV, 12'h555));
    // top up to full depth
    repeat (DEPTH - 7)
      conversion_queue.push_back(make_word(OP_CONV, RAW_W'($urandom_range(1, 4095))));
    // drops while full, a zero among them that must not saturate
    conversion_queue.push_back(make_word(OP_CONV, 12'd0));
    conversion_queue.push_back(make_word(OP_CONV, 12'hFFF));
    conversion_queue.push_back(make_word(OP_CLEAR, 12'hFFF));
    conversion_queue.push_back(make_word(OP_CLEAR, 12'd0));    // clear when already empty
    // sender pauses here until every reading is back
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cal(cal_plan[p]);
      calm = (p == 2);
      queue_random(PHASE_WORDS);
      if (p == 4) long_hold_req = 1'b1;
      wait_idle();
    end

    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d readings: %0d conversions, %0d saturated, %0d dropped, %0d clears",
             readings_checked, n_conversions, n_saturated, n_dropped, n_clears);
    $display("calibration swept over %0d settings including 0 and 4095", NUM_PHASES + 1);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("supply_voltage_from_reference_avg verification clean");
    end else begin
      $display("supply_voltage_from_reference_avg verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/svfra_pkg.sv
hw/rtl/svfra_div.sv
hw/rtl/supply_voltage_from_reference_avg.sv
tb/sv/tb.sv
